>>> design/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, constants and helper functions of the DH forward kinematics
// chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dhfk_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int DATA_WIDTH_DEF        = 32;

  localparam int IN_TDATA_W  = 160;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 136;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

  typedef enum logic [2:0] {
    LOP_S_CA,
    LOP_S_SA,
    LOP_A_C,
    LOP_C_CA,
    LOP_C_SA,
    LOP_A_S
  } link_op_t;

  typedef struct packed {
    logic       load;
    logic       ang_sel;
    logic       ang_load;
    logic       ang_step;
    logic       cordic_init;
    logic       cordic_iter;
    logic [4:0] iter;
    logic       cordic_store;
    logic       mul;
    logic       chain;
    link_op_t   lop;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] kk;
    logic       link_wr;
    logic       acc_init;
    logic       acc_add;
    logic       nt_wr;
    logic       commit;
    logic       out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic ang_ok;
    logic first_link;
    logic last_link;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd843314857;
      5'd1:  r = 32'sd497837829;
      5'd2:  r = 32'sd263043837;
      5'd3:  r = 32'sd133525159;
      5'd4:  r = 32'sd67021687;
      5'd5:  r = 32'sd33543516;
      5'd6:  r = 32'sd16775851;
      5'd7:  r = 32'sd8388437;
      5'd8:  r = 32'sd4194283;
      5'd9:  r = 32'sd2097149;
      5'd10: r = 32'sd1048576;
      5'd11: r = 32'sd524288;
      5'd12: r = 32'sd262144;
      5'd13: r = 32'sd131072;
      5'd14: r = 32'sd65536;
      5'd15: r = 32'sd32768;
      5'd16: r = 32'sd16384;
      5'd17: r = 32'sd8192;
      5'd18: r = 32'sd4096;
      5'd19: r = 32'sd2048;
      5'd20: r = 32'sd1024;
      5'd21: r = 32'sd512;
      5'd22: r = 32'sd256;
      5'd23: r = 32'sd128;
      5'd24: r = 32'sd64;
      5'd25: r = 32'sd32;
      5'd26: r = 32'sd16;
      5'd27: r = 32'sd8;
      5'd28: r = 32'sd4;
      5'd29: r = 32'sd2;
      5'd30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/dhfk_datapath.sv
// ----------------------------------------------------------------------------
// dhfk_datapath
// Operand registers, shared CORDIC unit, shared multiplier with accumulator,
// link and chain transform storage, and the output row register.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_datapath #(
  parameter int DATA_WIDTH = dhfk_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire dhfk_pkg::dp_cmd_t                   cmd,
  input  wire logic [dhfk_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [dhfk_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic                                in_tlast,
  output dhfk_pkg::dp_sts_t                        sts,
  output logic      [dhfk_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast
);
  import dhfk_pkg::*;

  localparam int FRAC = DATA_WIDTH - 2;
  localparam int W    = DATA_WIDTH + 2;
  localparam int TW   = 96;
  localparam int UP   = (FRAC >= 30) ? FRAC - 30 : 0;
  localparam int DN   = (FRAC >= 30) ? 0 : 30 - FRAC;

  logic signed [31:0] a_r, alpha_r, theta_r, q_r, dz_r;
  logic               rev_r, first_r, last_r;
  logic signed [35:0] ang_r;
  logic               flip_r;
  logic signed [W-1:0] x_r, y_r, z_r;
  logic signed [31:0] s_r, c_r, sa_r, ca_r;
  logic signed [31:0] lk_r [12];
  logic signed [31:0] t_r  [3][4];
  logic signed [31:0] nt_r [3][4];
  logic signed [63:0] p_r;
  logic signed [67:0] acc_r;

  logic signed [31:0] in_a, in_alpha, in_d, in_theta, in_q;
  logic signed [32:0] dq_sum;
  logic signed [35:0] ang_f;
  logic               flip_f;
  logic signed [W-1:0] step, xs, ys;
  logic signed [TW-1:0] xw, yw;
  logic signed [31:0] xf, yf;
  logic signed [31:0] t_row [4];
  logic signed [31:0] ma, mb;
  logic signed [63:0] rv;
  logic signed [31:0] link_val;

  assign in_a     = in_tdata[31:0];
  assign in_alpha = in_tdata[63:32];
  assign in_d     = in_tdata[95:64];
  assign in_theta = in_tdata[127:96];
  assign in_q     = in_tdata[159:128];
  assign dq_sum   = 33'(in_d) + 33'(in_q);

  assign sts.ang_ok     = !(ang_r > PI_Q30) && !(ang_r < -PI_Q30);
  assign sts.first_link = first_r;
  assign sts.last_link  = last_r;

  always_comb begin
    ang_f  = ang_r;
    flip_f = 1'b0;
    if (ang_r > HALF_PI_Q30) begin
      ang_f  = ang_r - PI_Q30;
      flip_f = 1'b1;
    end else if (ang_r < -HALF_PI_Q30) begin
      ang_f  = ang_r + PI_Q30;
      flip_f = 1'b1;
    end
  end

  assign step = W'((TW'(atan_q30(cmd.iter)) <<< UP) >>> DN);
  assign xs   = x_r >>> cmd.iter;
  assign ys   = y_r >>> cmd.iter;

  always_comb begin
    xw = (TW'(x_r) >>> UP) <<< DN;
    yw = (TW'(y_r) >>> UP) <<< DN;
    if (flip_r) begin
      xw = -xw;
      yw = -yw;
    end
    if (xw > TW'(ONE_Q30)) begin
      xf = 32'(ONE_Q30);
    end else if (xw < -TW'(ONE_Q30)) begin
      xf = -32'(ONE_Q30);
    end else begin
      xf = xw[31:0];
    end
    if (yw > TW'(ONE_Q30)) begin
      yf = 32'(ONE_Q30);
    end else if (yw < -TW'(ONE_Q30)) begin
      yf = -32'(ONE_Q30);
    end else begin
      yf = yw[31:0];
    end
  end

  always_comb begin
    t_row = t_r[cmd.row];
  end

  always_comb begin
    ma = t_row[cmd.kk];
    mb = lk_r[{cmd.kk, cmd.col}];
    if (!cmd.chain) begin
      unique case (cmd.lop)
        LOP_S_CA: begin ma = s_r; mb = ca_r; end
        LOP_S_SA: begin ma = s_r; mb = sa_r; end
        LOP_A_C:  begin ma = a_r; mb = c_r;  end
        LOP_C_CA: begin ma = c_r; mb = ca_r; end
        LOP_C_SA: begin ma = c_r; mb = sa_r; end
        LOP_A_S:  begin ma = a_r; mb = s_r;  end
        default:  begin ma = s_r; mb = ca_r; end
      endcase
    end
  end

  always_comb begin
    rv = (p_r + 64'sd536870912) >>> 30;
    if (cmd.lop == LOP_S_CA || cmd.lop == LOP_C_SA) begin
      rv = -rv;
    end
    link_val = sat32(68'(rv));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= in_a;
      alpha_r <= in_alpha;
      theta_r <= in_theta;
      q_r     <= in_q;
      rev_r   <= in_tuser[0];
      first_r <= in_tuser[1];
      last_r  <= in_tlast;
      dz_r    <= in_tuser[0] ? in_d : sat32(68'(dq_sum));
    end
    if (cmd.ang_load) begin
      if (!cmd.ang_sel) begin
        ang_r <= 36'(alpha_r) <<< 2;
      end else if (rev_r) begin
        ang_r <= (36'(theta_r) + 36'(q_r)) <<< 2;
      end else begin
        ang_r <= 36'(theta_r) <<< 2;
      end
    end
    if (cmd.ang_step) begin
      if (ang_r > PI_Q30) begin
        ang_r <= ang_r - TWO_PI_Q30;
      end else begin
        ang_r <= ang_r + TWO_PI_Q30;
      end
    end
    if (cmd.cordic_init) begin
      flip_r <= flip_f;
      z_r    <= W'((TW'(ang_f) <<< UP) >>> DN);
      x_r    <= W'((TW'(GAIN_Q30) <<< UP) >>> DN);
      y_r    <= '0;
    end
    if (cmd.cordic_iter) begin
      if (!z_r[W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step;
      end
    end
    if (cmd.cordic_store) begin
      if (!cmd.ang_sel) begin
        ca_r <= xf;
        sa_r <= yf;
      end else begin
        c_r <= xf;
        s_r <= yf;
      end
    end
    if (cmd.mul) begin
      p_r <= ma * mb;
    end
    if (cmd.link_wr) begin
      lk_r[0]  <= c_r;
      lk_r[4]  <= s_r;
      lk_r[8]  <= '0;
      lk_r[9]  <= sa_r;
      lk_r[10] <= ca_r;
      lk_r[11] <= dz_r;
      case (cmd.lop)
        LOP_S_CA: lk_r[1] <= link_val;
        LOP_S_SA: lk_r[2] <= link_val;
        LOP_A_C:  lk_r[3] <= link_val;
        LOP_C_CA: lk_r[5] <= link_val;
        LOP_C_SA: lk_r[6] <= link_val;
        default:  lk_r[7] <= link_val;
      endcase
    end
    if (cmd.acc_init) begin
      acc_r <= (cmd.col == 2'd3) ? (68'(t_row[3]) <<< 28) : '0;
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + ((cmd.col == 2'd3) ? (68'(p_r) >>> 2) : 68'(p_r));
    end
    if (cmd.nt_wr) begin
      nt_r[cmd.row][cmd.col] <= (cmd.col == 2'd3)
          ? sat32((acc_r + 68'sd134217728) >>> 28)
          : sat32((acc_r + 68'sd536870912) >>> 30);
    end
    if (cmd.commit) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          t_r[r][c] <= first_r ? lk_r[r*4+c] : nt_r[r][c];
        end
      end
    end
    if (cmd.out_ld) begin
      out_tdata <= {6'b0, t_row[3], t_row[2], t_row[1], t_row[0], cmd.row};
      out_tuser <= (cmd.row == 2'd2) && last_r;
      out_tlast <= (cmd.row == 2'd2);
    end
  end

endmodule

`default_nettype wire

>>> design/dhfk_ctrl.sv
// ----------------------------------------------------------------------------
// dhfk_ctrl
// Sequencer for one link: angle reduction, two CORDIC runs, link products,
// chain product if not the first link, commit, three output rows if emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_ctrl #(
  parameter int CORDIC_ITERATIONS = dhfk_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire dhfk_pkg::dp_sts_t sts,
  output dhfk_pkg::dp_cmd_t      cmd
);
  import dhfk_pkg::*;

  localparam int CW = $clog2(CORDIC_ITERATIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_ANG_LD, S_ANG_RED, S_CORD, S_CSTORE,
    S_LINK, S_CHAIN, S_COMMIT, S_OUT_LD, S_OUT
  } state_t;

  state_t        state_r;
  logic          sel_r, emit_r, out_valid_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]    op_r, ph_r;
  logic [1:0]    row_r, col_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.ang_sel = sel_r;
    cmd.iter    = 5'(cnt_r);
    cmd.lop     = link_op_t'(op_r);
    cmd.row     = row_r;
    cmd.col     = col_r;
    cmd.kk      = ph_r[1:0];
    unique case (state_r)
      S_IDLE:    cmd.load = in_tvalid;
      S_ANG_LD:  cmd.ang_load = 1'b1;
      S_ANG_RED: begin
        cmd.cordic_init = sts.ang_ok;
        cmd.ang_step    = !sts.ang_ok;
      end
      S_CORD:    cmd.cordic_iter = 1'b1;
      S_CSTORE:  cmd.cordic_store = 1'b1;
      S_LINK: begin
        cmd.mul     = (ph_r == 3'd0);
        cmd.link_wr = (ph_r != 3'd0);
      end
      S_CHAIN: begin
        cmd.chain = 1'b1;
        case (ph_r) inside
          3'd0: begin
            cmd.acc_init = 1'b1;
            cmd.mul      = 1'b1;
          end
          3'd1, 3'd2: begin
            cmd.acc_add = 1'b1;
            cmd.mul     = 1'b1;
          end
          3'd3: cmd.acc_add = 1'b1;
          default: cmd.nt_wr = 1'b1;
        endcase
      end
      S_COMMIT:  cmd.commit = 1'b1;
      S_OUT_LD:  cmd.out_ld = 1'b1;
      S_OUT: begin
        cmd.out_ld = out_tready && (row_r != 2'd2);
        cmd.row    = row_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      emit_r      <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      op_r        <= '0;
      ph_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        emit_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sel_r   <= 1'b0;
            state_r <= S_ANG_LD;
          end
        end
        S_ANG_LD: state_r <= S_ANG_RED;
        S_ANG_RED: begin
          if (sts.ang_ok) begin
            cnt_r   <= '0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cnt_r == CW'(CORDIC_ITERATIONS - 1)) begin
            state_r <= S_CSTORE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CSTORE: begin
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_ANG_LD;
          end else begin
            op_r    <= '0;
            ph_r    <= '0;
            state_r <= S_LINK;
          end
        end
        S_LINK: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r <= 3'd0;
            if (op_r == 3'(LOP_A_S)) begin
              row_r   <= '0;
              col_r   <= '0;
              state_r <= sts.first_link ? S_COMMIT : S_CHAIN;
            end else begin
              op_r <= op_r + 3'd1;
            end
          end
        end
        S_CHAIN: begin
          if (ph_r == 3'd4) begin
            ph_r <= '0;
            if (col_r == 2'd3) begin
              col_r <= '0;
              if (row_r == 2'd2) begin
                state_r <= S_COMMIT;
              end else begin
                row_r <= row_r + 2'd1;
              end
            end else begin
              col_r <= col_r + 2'd1;
            end
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_COMMIT: begin
          row_r   <= '0;
          state_r <= (emit_r || sts.last_link) ? S_OUT_LD : S_IDLE;
        end
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            if (row_r == 2'd2) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              row_r <= row_r + 2'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/dh_forward_kinematics_chain.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg forward kinematics: one link per request, cumulative
// 3x4 transform delivered as three row requests.
//
//   Channel | Fields (tdata low bit up / tuser / tlast)
//   in_     | length, twist, offset, angle, joint value / revolute, first / last
//   out_    | row index, rot col 0..2, translation / chain done / row last
//   cfg_    | emit every link (1 bit, reset 1)
//
// A link runs, from one accepted request to the next, the angle reduction, two
// CORDIC runs, the six link products, the 36 chain products on the one shared
// multiplier, and the accept, the commit and the three rows. A first link skips
// the chain product; a link that emits nothing skips the rows.
// Reset is synchronous; the transform is undefined until a first link.
// A new request is taken only after the rows of the previous one are taken;
// output stalls hold the row register and add their cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module dh_forward_kinematics_chain #(
  parameter int CORDIC_ITERATIONS = dhfk_pkg::CORDIC_ITERATIONS_DEF,
  parameter int DATA_WIDTH        = dhfk_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic                             cfg_wr_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // link_length, link_twist, link_offset, link_angle, joint_value
  input  wire logic [dhfk_pkg::IN_TDATA_W-1:0]  in_tdata,
  // is_revolute, first_link
  input  wire logic [dhfk_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // row_index, rot_col0, rot_col1, rot_col2, translation, zero fill
  output logic [dhfk_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // chain_done
  output logic                                  out_tuser,
  output logic                                  out_tlast
);
  import dhfk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dhfk_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dhfk_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .sts      (sts),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

endmodule

`default_nettype wire

>>> design/dhfk_checker.sv
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level checks of the DH forward kinematics chain, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfk_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             cfg_wr_en,
  input wire logic                             cfg_wr_data,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [dhfk_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [dhfk_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                             in_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [dhfk_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tuser,
  input wire logic                             out_tlast
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result shown right after a request was taken");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while rows are pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled row changed");

  a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap between rows of one link");

  a_last_on_row2: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd2)))
    else $error("row last flag does not match row index");

endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (.*);

`default_nettype wire
